@@ src/reb_pkg.sv @@
package reb_pkg;

  localparam int DivDw = 33;
  localparam int DivVw = 25;

  localparam logic [1:0] REQ_REGION = 2'd0;
  localparam logic [1:0] REQ_ZONE   = 2'd1;
  localparam logic [1:0] REQ_PIXEL  = 2'd2;
  localparam logic [1:0] REQ_FINISH = 2'd3;

  localparam logic [1:0] ST_INVALID = 2'd0;
  localparam logic [1:0] ST_NO_MEAS = 2'd1;
  localparam logic [1:0] ST_IN_BAND = 2'd2;
  localparam logic [1:0] ST_UPDATED = 2'd3;

  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_TARGET_LUMA  = 3'd2;
  localparam logic [2:0] CFG_BIAS_MIN     = 3'd3;
  localparam logic [2:0] CFG_BIAS_MAX     = 3'd4;
  localparam logic [2:0] CFG_MIN_ZONES    = 3'd5;

  typedef struct packed {
    logic             start;
    logic [DivDw-1:0] dividend;
    logic [DivVw-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivDw-1:0] quotient;
  } div_rsp_t;

endpackage

@@ src/region_exposure_bias.sv @@
// Region, zone and pixel transactions are taken only while idle; the block stays ready for them.
// A finish transaction runs up to seven divisions one after another on the shared
// bit-serial divider plus a read state and an accumulate state per zone of the window,
// and the result then waits in an output register until it is taken.
// Reset is asynchronous and active low; it restores the register defaults and marks
// every zone entry as zero through per-entry valid flags.
module region_exposure_bias #(
  parameter int GRID_ROWS = 16,
  parameter int GRID_COLS = 16,
  parameter int MAX_FRAME = 4096,
  parameter int STAT_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [11:0] pos_x_i,
  input  logic [11:0] pos_y_i,
  input  logic [12:0] size_w_i,
  input  logic [12:0] size_h_i,
  input  logic [3:0]  zone_row_i,
  input  logic [3:0]  zone_col_i,
  input  logic [11:0] red_i,
  input  logic [11:0] green_r_i,
  input  logic [11:0] green_b_i,
  input  logic [11:0] blue_i,
  input  logic [7:0]  pixel_luma_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [9:0]  measured_luma_o,
  output logic [15:0] ev_bias_o
);

  localparam int Zones   = GRID_ROWS * GRID_COLS;
  localparam int Aw      = Zones > 1 ? $clog2(Zones) : 1;
  localparam int Rw      = $clog2(GRID_ROWS + 1);
  localparam int Cw      = $clog2(GRID_COLS + 1);
  localparam int CntW    = $clog2(Zones + 1);
  localparam int SumW    = STAT_BITS + CntW;
  localparam int StatMax = (1 << STAT_BITS) - 1;
  localparam logic [13:0] MaxFrameW = 14'(MAX_FRAME);
  localparam int GxShift = 13 + $clog2(GRID_COLS);
  localparam int GyShift = 13 + $clog2(GRID_ROWS);
  localparam int GxMul   = ((1 << GxShift) + GRID_COLS - 1) / GRID_COLS;
  localparam int GyMul   = ((1 << GyShift) + GRID_ROWS - 1) / GRID_ROWS;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_CHECK  = 16'h0002,
    S_GX     = 16'h0004,
    S_GY     = 16'h0008,
    S_R0     = 16'h0010,
    S_R1     = 16'h0020,
    S_C0     = 16'h0040,
    S_C1     = 16'h0080,
    S_WSTART = 16'h0100,
    S_WADDR  = 16'h0200,
    S_WACC   = 16'h0400,
    S_ZMEAN  = 16'h0800,
    S_PMEAN  = 16'h1000,
    S_DECIDE = 16'h2000,
    S_BIAS   = 16'h4000,
    S_DONE   = 16'h8000
  } state_e;

  state_e state_q, state_d;

  logic [12:0] fw_q, fh_q;
  logic [7:0]  tgt_q;
  logic [15:0] bmin_q, bmax_q;
  logic [8:0]  minz_q;

  logic [11:0] held_x_q, held_y_q;
  logic [12:0] held_w_q, held_h_q;
  logic [25:0] held_area_q;
  logic [32:0] pix_sum_q;
  logic [24:0] pix_cnt_q;

  logic [Zones-1:0] zone_valid_q;
  logic             rd_valid_q;

  logic [12:0]     gx_q, gy_q;
  logic [Rw-1:0]   r0_q, r1_q, r_q;
  logic [Cw-1:0]   c0_q, c1_q, c_q;
  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] cnt_q;
  logic [9:0]      meas_q;
  logic [1:0]      status_q;
  logic [15:0]     bias_q;
  logic            div_pend_q;

  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [9:0]  out_meas_q;
  logic [15:0] out_bias_q;

  logic in_acc, out_free;
  assign in_ready_o  = state_q == S_IDLE;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  logic [12:0] fw_lim, fh_lim;
  assign fw_lim = ({1'b0, fw_q} > MaxFrameW) ? MaxFrameW[12:0] : fw_q;
  assign fh_lim = ({1'b0, fh_q} > MaxFrameW) ? MaxFrameW[12:0] : fh_q;

  logic [31:0] gx_prod, gy_prod, gx_quo, gy_quo;
  assign gx_prod = 32'(fw_lim) * 32'(GxMul);
  assign gy_prod = 32'(fh_lim) * 32'(GyMul);
  assign gx_quo  = gx_prod >> GxShift;
  assign gy_quo  = gy_prod >> GyShift;

  logic [13:0] x2, y2, px_end, py_end;
  logic [12:0] px, py;
  logic        region_bad;
  assign x2     = 14'(held_x_q) + 14'(held_w_q);
  assign y2     = 14'(held_y_q) + 14'(held_h_q);
  assign px     = 13'(held_x_q) + 13'(held_w_q[12:2]);
  assign py     = 13'(held_y_q) + 13'(held_h_q[12:2]);
  assign px_end = 14'(px) + 14'(held_w_q[12:1]);
  assign py_end = 14'(py) + 14'(held_h_q[12:1]);
  assign region_bad = (held_w_q == '0) || (held_h_q == '0) ||
                      ({1'b0, held_x_q} > fw_lim) || (x2 > {1'b0, fw_lim}) ||
                      ({1'b0, held_y_q} > fh_lim) || (y2 > {1'b0, fh_lim});

  logic [25:0] new_area;
  logic        pix_inside;
  assign new_area   = 26'(size_w_i) * 26'(size_h_i);
  assign pix_inside = (pos_x_i >= held_x_q) && ({2'b0, pos_x_i} < x2) &&
                      (pos_y_i >= held_y_q) && ({2'b0, pos_y_i} < y2) &&
                      (pix_cnt_q != '1);

  logic [11:0]          g_mean, m_max;
  logic [31:0]          m_sat;
  logic                 zone_in_grid, zone_we;
  logic [Aw-1:0]        zone_waddr, zone_raddr;
  logic [STAT_BITS-1:0] zone_wdata, zone_rdata;
  always_comb begin
    g_mean = 12'((13'(green_r_i) + 13'(green_b_i)) >> 1);
    m_max  = red_i;
    if (g_mean > m_max) begin
      m_max = g_mean;
    end
    if (blue_i > m_max) begin
      m_max = blue_i;
    end
    m_sat = (32'(m_max) > 32'(StatMax)) ? 32'(StatMax) : 32'(m_max);
  end
  assign zone_wdata   = m_sat[STAT_BITS-1:0];
  assign zone_in_grid = (32'(zone_row_i) < 32'(GRID_ROWS)) &&
                        (32'(zone_col_i) < 32'(GRID_COLS));
  assign zone_we      = in_acc && (req_type_i == reb_pkg::REQ_ZONE) && zone_in_grid;
  assign zone_waddr   = Aw'(32'(zone_row_i) * GRID_COLS + 32'(zone_col_i));
  assign zone_raddr   = Aw'(32'(r_q) * GRID_COLS + 32'(c_q));

  reb_ram #(
    .WIDTH (STAT_BITS),
    .DEPTH (Zones)
  ) u_zone_ram (
    .clk_i   (clk_i),
    .we_i    (zone_we),
    .waddr_i (zone_waddr),
    .wdata_i (zone_wdata),
    .raddr_i (zone_raddr),
    .rdata_o (zone_rdata)
  );

  reb_pkg::div_req_t div_req;
  reb_pkg::div_rsp_t div_rsp;
  logic              div_need;
  logic              zone_ok, pix_need, out_band;
  logic [32:0]       quo;
  logic [17:0]       bias_raw;
  logic [15:0]       bias_lim;

  assign quo      = div_rsp.quotient;
  assign zone_ok  = (32'(cnt_q) > 32'(minz_q)) && (cnt_q != '0);
  assign pix_need = (meas_q == '0) && (pix_cnt_q != '0);
  assign out_band = (11'(meas_q) >= 11'(tgt_q) + 11'd20) ||
                    (11'(meas_q) + 11'd10 <= 11'(tgt_q));
  assign bias_raw = quo[17:0];
  always_comb begin
    bias_lim = (bias_raw < {2'b0, bmin_q}) ? bmin_q : bias_raw[15:0];
    if (bias_raw > {2'b0, bmax_q} && bias_raw >= {2'b0, bmin_q}) begin
      bias_lim = bmax_q;
    end
    if (bmin_q > bmax_q && bias_lim > bmax_q) begin
      bias_lim = bmax_q;
    end
  end

  always_comb begin
    div_need         = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_q)
      S_R0: begin
        div_need         = 1'b1;
        div_req.dividend = 33'(py);
        div_req.divisor  = 25'(gy_q);
      end
      S_R1: begin
        div_need         = 1'b1;
        div_req.dividend = 33'(py_end);
        div_req.divisor  = 25'(gy_q);
      end
      S_C0: begin
        div_need         = 1'b1;
        div_req.dividend = 33'(px);
        div_req.divisor  = 25'(gx_q);
      end
      S_C1: begin
        div_need         = 1'b1;
        div_req.dividend = 33'(px_end);
        div_req.divisor  = 25'(gx_q);
      end
      S_ZMEAN: begin
        div_need         = zone_ok;
        div_req.dividend = 33'(sum_q);
        div_req.divisor  = 25'(cnt_q);
      end
      S_PMEAN: begin
        div_need         = pix_need;
        div_req.dividend = pix_sum_q;
        div_req.divisor  = pix_cnt_q;
      end
      S_BIAS: begin
        div_need         = 1'b1;
        div_req.dividend = 33'({tgt_q, 10'b0});
        div_req.divisor  = 25'(meas_q);
      end
      default: begin
        div_need = 1'b0;
      end
    endcase
    div_req.start = div_need && !div_pend_q;
  end

  reb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic last_col, last_row;
  assign last_col = (c_q + Cw'(1)) == c1_q;
  assign last_row = (r_q + Rw'(1)) == r1_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && req_type_i == reb_pkg::REQ_FINISH) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK:  state_d = region_bad ? S_DONE : S_GX;
      S_GX:     state_d = S_GY;
      S_GY:     state_d = S_R0;
      S_R0:     state_d = div_rsp.done ? S_R1 : S_R0;
      S_R1:     state_d = div_rsp.done ? S_C0 : S_R1;
      S_C0:     state_d = div_rsp.done ? S_C1 : S_C0;
      S_C1:     state_d = div_rsp.done ? S_WSTART : S_C1;
      S_WSTART: state_d = (r0_q < r1_q && c0_q < c1_q) ? S_WADDR : S_ZMEAN;
      S_WADDR:  state_d = S_WACC;
      S_WACC:   state_d = (last_col && last_row) ? S_ZMEAN : S_WADDR;
      S_ZMEAN: begin
        if (!zone_ok || div_rsp.done) begin
          state_d = S_PMEAN;
        end
      end
      S_PMEAN: begin
        if (!pix_need || div_rsp.done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (meas_q == '0 || !out_band) begin
          state_d = S_DONE;
        end else begin
          state_d = S_BIAS;
        end
      end
      S_BIAS:   state_d = div_rsp.done ? S_DONE : S_BIAS;
      S_DONE:   state_d = out_free ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fw_q         <= 13'd1920;
      fh_q         <= 13'd1080;
      tgt_q        <= 8'd128;
      bmin_q       <= 16'd512;
      bmax_q       <= 16'd4096;
      minz_q       <= 9'd0;
      held_x_q     <= '0;
      held_y_q     <= '0;
      held_w_q     <= '0;
      held_h_q     <= '0;
      held_area_q  <= '0;
      pix_sum_q    <= '0;
      pix_cnt_q    <= '0;
      zone_valid_q <= '0;
      div_pend_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          reb_pkg::CFG_FRAME_WIDTH:  fw_q   <= cfg_data_i[12:0];
          reb_pkg::CFG_FRAME_HEIGHT: fh_q   <= cfg_data_i[12:0];
          reb_pkg::CFG_TARGET_LUMA:  tgt_q  <= cfg_data_i[7:0];
          reb_pkg::CFG_BIAS_MIN:     bmin_q <= cfg_data_i;
          reb_pkg::CFG_BIAS_MAX:     bmax_q <= cfg_data_i;
          reb_pkg::CFG_MIN_ZONES:    minz_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (in_acc && req_type_i == reb_pkg::REQ_REGION && new_area > held_area_q) begin
        held_x_q    <= pos_x_i;
        held_y_q    <= pos_y_i;
        held_w_q    <= size_w_i;
        held_h_q    <= size_h_i;
        held_area_q <= new_area;
      end
      if (in_acc && req_type_i == reb_pkg::REQ_PIXEL && pix_inside) begin
        pix_sum_q <= pix_sum_q + 33'(pixel_luma_i);
        pix_cnt_q <= pix_cnt_q + 25'd1;
      end
      if (zone_we) begin
        zone_valid_q[zone_waddr] <= 1'b1;
      end
      if (div_req.start) begin
        div_pend_q <= 1'b1;
      end else if (div_rsp.done) begin
        div_pend_q <= 1'b0;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_DONE && out_free) begin
        held_x_q    <= '0;
        held_y_q    <= '0;
        held_w_q    <= '0;
        held_h_q    <= '0;
        held_area_q <= '0;
        pix_sum_q   <= '0;
        pix_cnt_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_CHECK: begin
        sum_q    <= '0;
        cnt_q    <= '0;
        meas_q   <= '0;
        bias_q   <= '0;
        status_q <= reb_pkg::ST_INVALID;
      end
      S_GX: begin
        gx_q <= (gx_quo == '0) ? 13'd1 : gx_quo[12:0];
      end
      S_GY: begin
        gy_q <= (gy_quo == '0) ? 13'd1 : gy_quo[12:0];
      end
      S_R0: begin
        if (div_rsp.done) begin
          r0_q <= (quo > 33'(GRID_ROWS)) ? Rw'(GRID_ROWS) : quo[Rw-1:0];
        end
      end
      S_R1: begin
        if (div_rsp.done) begin
          r1_q <= (quo > 33'(GRID_ROWS)) ? Rw'(GRID_ROWS) : quo[Rw-1:0];
        end
      end
      S_C0: begin
        if (div_rsp.done) begin
          c0_q <= (quo > 33'(GRID_COLS)) ? Cw'(GRID_COLS) : quo[Cw-1:0];
        end
      end
      S_C1: begin
        if (div_rsp.done) begin
          c1_q <= (quo > 33'(GRID_COLS)) ? Cw'(GRID_COLS) : quo[Cw-1:0];
        end
      end
      S_WSTART: begin
        r_q <= r0_q;
        c_q <= c0_q;
      end
      S_WADDR: begin
        rd_valid_q <= zone_valid_q[zone_raddr];
      end
      S_WACC: begin
        if (rd_valid_q) begin
          sum_q <= sum_q + SumW'(zone_rdata);
        end
        cnt_q <= cnt_q + CntW'(1);
        if (last_col) begin
          c_q <= c0_q;
          r_q <= r_q + Rw'(1);
        end else begin
          c_q <= c_q + Cw'(1);
        end
      end
      S_ZMEAN: begin
        if (div_rsp.done) begin
          meas_q <= quo[11:2];
        end
      end
      S_PMEAN: begin
        if (div_rsp.done) begin
          meas_q <= quo[9:0];
        end
      end
      S_DECIDE: begin
        if (meas_q == '0) begin
          status_q <= reb_pkg::ST_NO_MEAS;
        end else if (!out_band) begin
          status_q <= reb_pkg::ST_IN_BAND;
        end
      end
      S_BIAS: begin
        if (div_rsp.done) begin
          bias_q   <= bias_lim;
          status_q <= reb_pkg::ST_UPDATED;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_status_q <= status_q;
          out_meas_q   <= meas_q;
          out_bias_q   <= bias_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign measured_luma_o = out_meas_q;
  assign ev_bias_o       = out_bias_q;

  a_done_requested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> div_pend_q)
    else $error("divider finished without a pending request");

  a_acc_after_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WACC) |-> ($past(state_q) == S_WADDR))
    else $error("zone accumulate without a preceding read");

  a_bias_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BIAS) |-> (meas_q != '0))
    else $error("bias division by a zero measure");

  a_walk_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WADDR) |-> (r_q < r1_q && c_q < c1_q))
    else $error("zone walk left the window");

endmodule

@@ src/reb_ram.sv @@
module reb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/reb_div.sv @@
module reb_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  reb_pkg::div_req_t req_i,
  output reb_pkg::div_rsp_t rsp_o
);

  localparam int Dw = reb_pkg::DivDw;
  localparam int Vw = reb_pkg::DivVw;

  logic          busy_q;
  logic          done_q;
  logic [5:0]    cnt_q;
  logic [Vw-1:0] rem_q;
  logic [Vw-1:0] dvs_q;
  logic [Dw-1:0] quo_q;
  logic [Vw:0]   shifted;
  logic          fits;

  assign shifted = {rem_q, quo_q[Dw-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(Dw);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= Vw'(shifted - {1'b0, dvs_q});
      end else begin
        rem_q <= shifted[Vw-1:0];
      end
      quo_q <= {quo_q[Dw-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ verif/reb_checker.sv @@
module reb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  req_type_i,
  input  logic [11:0] pos_x_i,
  input  logic [11:0] pos_y_i,
  input  logic [12:0] size_w_i,
  input  logic [12:0] size_h_i,
  input  logic [3:0]  zone_row_i,
  input  logic [3:0]  zone_col_i,
  input  logic [11:0] red_i,
  input  logic [11:0] green_r_i,
  input  logic [11:0] green_b_i,
  input  logic [11:0] blue_i,
  input  logic [7:0]  pixel_luma_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [9:0]  measured_luma_i,
  input  logic [15:0] ev_bias_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          updates_o
);

  localparam int unsigned GridRows = 16;
  localparam int unsigned GridCols = 16;
  localparam int unsigned MaxFrame = 4096;
  localparam int unsigned StatMax  = 4095;
  localparam int unsigned CountMax = (1 << 25) - 1;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  luma;
    logic [15:0] bias;
  } exposure_result_t;

  int unsigned frame_w, frame_h, target, bias_lo, bias_hi, min_zones;
  int unsigned held_x, held_y, held_w, held_h, pix_cnt;
  longint unsigned pix_sum;
  logic [11:0] zone_mem [GridRows*GridCols];
  exposure_result_t exposure_q[$];
  int fails, results, updates;

  assign fail_count_o = fails;
  assign pending_o    = exposure_q.size();
  assign results_o    = results;
  assign updates_o    = updates;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("reb_checker: %s mismatch, got %0d, expected %0d", what, got, want);
    fails++;
  endtask

  function automatic int unsigned window_mean(input int unsigned fw, input int unsigned fh);
    int unsigned gx, gy, px, py, r0, r1, c0, c1, sum, cnt;
    gx = fw / GridCols;
    gy = fh / GridRows;
    sum = 0;
    cnt = 0;
    if (gx == 0) gx = 1;
    if (gy == 0) gy = 1;
    px = held_x + held_w / 4;
    py = held_y + held_h / 4;
    r0 = py / gy;
    r1 = (py + held_h / 2) / gy;
    c0 = px / gx;
    c1 = (px + held_w / 2) / gx;
    if (r1 > GridRows) r1 = GridRows;
    if (c1 > GridCols) c1 = GridCols;
    for (int unsigned r = r0; r < r1; r++) begin
      for (int unsigned c = c0; c < c1; c++) begin
        sum += zone_mem[r*GridCols + c];
        cnt++;
      end
    end
    if (cnt > min_zones && cnt > 0) return (sum / cnt) / 4;
    return 0;
  endfunction

  task automatic predict_request();
    int unsigned m, g, fw, fh, meas, b;
    exposure_result_t res;
    case (req_type_i)
      reb_pkg::REQ_REGION: begin
        if (longint'(size_w_i) * size_h_i > longint'(held_w) * held_h) begin
          held_x = pos_x_i;
          held_y = pos_y_i;
          held_w = size_w_i;
          held_h = size_h_i;
        end
      end
      reb_pkg::REQ_ZONE: begin
        g = (int'(green_r_i) + green_b_i) / 2;
        m = red_i;
        if (g > m) m = g;
        if (blue_i > m) m = blue_i;
        if (m > StatMax) m = StatMax;
        zone_mem[zone_row_i*GridCols + zone_col_i] = m;
      end
      reb_pkg::REQ_PIXEL: begin
        if (pos_x_i >= held_x && pos_x_i < held_x + held_w && pos_y_i >= held_y &&
            pos_y_i < held_y + held_h && pix_cnt < CountMax) begin
          pix_sum += pixel_luma_i;
          pix_cnt++;
        end
      end
      default: begin
        fw = (frame_w > MaxFrame) ? MaxFrame : frame_w;
        fh = (frame_h > MaxFrame) ? MaxFrame : frame_h;
        meas = 0;
        b = 0;
        if (held_w == 0 || held_h == 0 || held_x > fw || held_x + held_w > fw ||
            held_y > fh || held_y + held_h > fh) begin
          res.status = reb_pkg::ST_INVALID;
        end else begin
          meas = window_mean(fw, fh);
          if (meas == 0 && pix_cnt > 0) meas = pix_sum / pix_cnt;
          if (meas == 0) begin
            res.status = reb_pkg::ST_NO_MEAS;
          end else if (int'(meas) >= int'(target) + 20 || int'(meas) <= int'(target) - 10) begin
            b = (target * 1024) / meas;
            if (b < bias_lo) b = bias_lo;
            if (b > bias_hi) b = bias_hi;
            res.status = reb_pkg::ST_UPDATED;
          end else begin
            res.status = reb_pkg::ST_IN_BAND;
          end
        end
        res.luma = meas[9:0];
        res.bias = b[15:0];
        exposure_q.push_back(res);
        held_x = 0;
        held_y = 0;
        held_w = 0;
        held_h = 0;
        pix_sum = 0;
        pix_cnt = 0;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    exposure_result_t want;
    if (!rst_ni) begin
      frame_w = 1920;
      frame_h = 1080;
      target = 128;
      bias_lo = 512;
      bias_hi = 4096;
      min_zones = 0;
      held_x = 0;
      held_y = 0;
      held_w = 0;
      held_h = 0;
      pix_sum = 0;
      pix_cnt = 0;
      foreach (zone_mem[i]) zone_mem[i] = '0;
      exposure_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (exposure_q.size() == 0) begin
          report_mismatch("unexpected result, status", status_i, -1);
        end else begin
          want = exposure_q.pop_front();
          results++;
          if (want.status == reb_pkg::ST_UPDATED) updates++;
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (measured_luma_i !== want.luma)
            report_mismatch("measured_luma", measured_luma_i, want.luma);
          if (ev_bias_i !== want.bias) report_mismatch("ev_bias", ev_bias_i, want.bias);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          reb_pkg::CFG_FRAME_WIDTH:  frame_w = cfg_data_i[12:0];
          reb_pkg::CFG_FRAME_HEIGHT: frame_h = cfg_data_i[12:0];
          reb_pkg::CFG_TARGET_LUMA:  target = cfg_data_i[7:0];
          reb_pkg::CFG_BIAS_MIN:     bias_lo = cfg_data_i;
          reb_pkg::CFG_BIAS_MAX:     bias_hi = cfg_data_i;
          reb_pkg::CFG_MIN_ZONES:    min_zones = cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_request();
    end
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i = '0;
  logic [11:0] pos_x_i = '0;
  logic [11:0] pos_y_i = '0;
  logic [12:0] size_w_i = '0;
  logic [12:0] size_h_i = '0;
  logic [3:0]  zone_row_i = '0;
  logic [3:0]  zone_col_i = '0;
  logic [11:0] red_i = '0;
  logic [11:0] green_r_i = '0;
  logic [11:0] green_b_i = '0;
  logic [11:0] blue_i = '0;
  logic [7:0]  pixel_luma_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [9:0]  measured_luma_o;
  logic [15:0] ev_bias_o;

  int fail_count, pending, results, updates;
  int requests_sent;
  int idle_cycles = 0;
  bit quiet;
  bit long_hold_req;
  bit long_hold_done;
  int unsigned frame_w_cfg, frame_h_cfg, target_cfg;

  region_exposure_bias DUT (.*);

  reb_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .pos_x_i, .pos_y_i, .size_w_i,
    .size_h_i, .zone_row_i, .zone_col_i, .red_i, .green_r_i, .green_b_i, .blue_i,
    .pixel_luma_i, .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .measured_luma_i(measured_luma_o), .ev_bias_i(ev_bias_o), .fail_count_o(fail_count),
    .pending_o(pending), .results_o(results), .updates_o(updates)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // The receiver stalls in short bursts and, once, for a long stretch so that the
  // held result blocks the following finish transactions.
  initial begin
    forever begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (1500) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == 40000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push(input logic [1:0] rt, input int unsigned x, input int unsigned y,
                      input int unsigned w, input int unsigned h, input int unsigned zr,
                      input int unsigned zc, input int unsigned rd, input int unsigned gr,
                      input int unsigned gb, input int unsigned bl, input int unsigned lu);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= rt;
    pos_x_i      <= 12'(x);
    pos_y_i      <= 12'(y);
    size_w_i     <= 13'(w);
    size_h_i     <= 13'(h);
    zone_row_i   <= 4'(zr);
    zone_col_i   <= 4'(zc);
    red_i        <= 12'(rd);
    green_r_i    <= 12'(gr);
    green_b_i    <= 12'(gb);
    blue_i       <= 12'(bl);
    pixel_luma_i <= 8'(lu);
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
  endtask

  task automatic push_region(input int unsigned x, input int unsigned y,
                             input int unsigned w, input int unsigned h);
    push(reb_pkg::REQ_REGION, x, y, w, h, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom);
  endtask

  task automatic push_zone(input int unsigned r, input int unsigned c, input int unsigned rd,
                           input int unsigned gr, input int unsigned gb, input int unsigned bl);
    push(reb_pkg::REQ_ZONE, $urandom, $urandom, $urandom, $urandom, r, c, rd, gr, gb, bl,
         $urandom);
  endtask

  task automatic push_pixel(input int unsigned x, input int unsigned y, input int unsigned lu);
    push(reb_pkg::REQ_PIXEL, x, y, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, lu);
  endtask

  task automatic push_finish();
    push(reb_pkg::REQ_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 16'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      reb_pkg::CFG_FRAME_WIDTH:  frame_w_cfg = data & 'h1fff;
      reb_pkg::CFG_FRAME_HEIGHT: frame_h_cfg = data & 'h1fff;
      reb_pkg::CFG_TARGET_LUMA:  target_cfg = data & 'hff;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned fw, input int unsigned fh, input int unsigned tl,
                           input int unsigned bmin, input int unsigned bmax,
                           input int unsigned mz);
    drain();
    write_reg(reb_pkg::CFG_FRAME_WIDTH, fw);
    write_reg(reb_pkg::CFG_FRAME_HEIGHT, fh);
    write_reg(reb_pkg::CFG_TARGET_LUMA, tl);
    write_reg(reb_pkg::CFG_BIAS_MIN, bmin);
    write_reg(reb_pkg::CFG_BIAS_MAX, bmax);
    write_reg(reb_pkg::CFG_MIN_ZONES, mz);
  endtask

  function automatic int unsigned near_target(input int unsigned scale, input int unsigned top);
    int v;
    v = int'(target_cfg * scale) + $urandom_range(0, 40 * scale) - 20 * scale;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  // One exposure window: one to three regions, some zone statistics, pixels in the
  // largest region, then a finish. A few sequences are broken or carry noise.
  task automatic run_sequence();
    int unsigned lim_w, lim_h, x, y, w, h, bx, by, bw, bh, v;
    longint unsigned best_area;
    lim_w = (frame_w_cfg > 4096) ? 4096 : frame_w_cfg;
    lim_h = (frame_h_cfg > 4096) ? 4096 : frame_h_cfg;
    best_area = 0;
    bx = 0;
    by = 0;
    bw = 1;
    bh = 1;
    if ($urandom_range(0, 9) != 0) begin
      repeat ($urandom_range(1, 3)) begin
        x = $urandom_range(0, (lim_w > 4096 ? 4096 : lim_w) - 1);
        y = $urandom_range(0, lim_h - 1);
        if (x > 4095) x = 4095;
        if (y > 4095) y = 4095;
        w = $urandom_range(1, lim_w - x);
        h = $urandom_range(1, lim_h - y);
        if ($urandom_range(0, 7) == 0) begin
          w = $urandom_range(0, 4096);
          h = $urandom_range(0, 4096);
        end
        push_region(x, y, w, h);
        if (longint'(w) * h > best_area) begin
          best_area = longint'(w) * h;
          bx = x;
          by = y;
          bw = (w == 0) ? 1 : w;
          bh = (h == 0) ? 1 : h;
        end
      end
    end
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 2) == 0) begin
        push_zone($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        v = near_target(4, 4095);
        push_zone($urandom, $urandom, v, $urandom_range(0, v), $urandom_range(0, v),
                  $urandom_range(0, v));
      end
    end
    repeat ($urandom_range(0, 24)) begin
      x = bx + $urandom_range(0, bw - 1);
      y = by + $urandom_range(0, bh - 1);
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
      end
      push_pixel(x > 4095 ? 4095 : x, y > 4095 ? 4095 : y,
                 $urandom_range(0, 1) ? near_target(1, 255) : $urandom_range(0, 255));
    end
    if ($urandom_range(0, 15) != 0) push_finish();
  endtask

  initial begin
    frame_w_cfg = 1920;
    frame_h_cfg = 1080;
    target_cfg = 128;
    requests_sent = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    push_finish();
    push_region(0, 0, 0, 500);
    push_finish();
    push_region(4095, 4095, 4096, 4096);
    push_finish();
    push_zone(15, 15, 4095, 4095, 4095, 4095);
    push_zone(0, 0, 0, 0, 0, 0);
    push_zone(7, 7, 10, 4095, 4094, 100);
    push_zone(8, 8, 10, 20, 30, 4000);
    push_zone(8, 7, 4000, 0, 0, 5);
    push_region(0, 0, 1920, 1080);
    push_region(100, 100, 1080, 1920);
    push_finish();
    push_region(480, 270, 960, 540);
    push_pixel(480, 270, 255);
    push_pixel(1439, 809, 0);
    push_pixel(1440, 810, 77);
    push_finish();
    push_region(1000, 1000, 920, 80);
    push_pixel(1000, 1000, 128);
    push_finish();

    configure(4096, 4096, 255, 0, 65535, 0);
    long_hold_req = 1'b1;
    while (requests_sent < 300) run_sequence();
    configure(1, 1, 0, 65535, 0, 256);
    push_region(0, 0, 1, 1);
    push_finish();
    while (requests_sent < 400) run_sequence();
    configure(8191, 8191, 40, 16384, 2048, 3);
    while (requests_sent < 600) run_sequence();
    configure(64, 48, 200, 1000, 1200, 256);
    while (requests_sent < 800) run_sequence();
    for (int ph = 0; ph < 4; ph++) begin
      configure($urandom_range(16, 4096), $urandom_range(16, 4096), $urandom_range(0, 255),
                $urandom_range(0, 4096), $urandom_range(1024, 65535), $urandom_range(0, 8));
      while (requests_sent < 1100 + 250 * ph) run_sequence();
      if (ph == 3) quiet = 1'b1;
    end
    while (requests_sent < 1950) run_sequence();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    $display("tb: %0d requests over nine register settings, %0d finish results checked",
             requests_sent, results);
    $display("tb: %0d of those results carried a new bias", updates);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
